// ----- rtl/core/dws_pkg.sv -----
// shared types and constants of the dependency wave scheduler
package dws_pkg;

	localparam int MAX_TASKS_DEF = 64;
	localparam int MAX_RESULTS   = 64;
	localparam int NAME_W        = 8;
	localparam int KIND_W        = 2;
	localparam int LIMIT_W       = 7;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic [LIMIT_W-1:0] ISSUE_LIMIT_RST = LIMIT_W'(64);
	localparam logic               REG_ISSUE_LIMIT = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_EXEC   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SELF = 2'd1,
		OP_RUN  = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [NAME_W-1:0] dep;
		logic [NAME_W-1:0] pre;
	} cmd_t;

endpackage

// ----- rtl/core/dws_front.sv -----
// input side: accepts words, classifies them and queues them for the engine
module dws_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          mode,
	input  logic [dws_pkg::NAME_W-1:0]    dependent_name,
	input  logic [dws_pkg::NAME_W-1:0]    prerequisite_name,
	output logic                          cmd_valid,
	output dws_pkg::cmd_t                 cmd,
	input  logic                          cmd_pop
);
	import dws_pkg::*;

	cmd_t        queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	cmd_t        cls;

	// classify the incoming word
	always_comb begin
		cls.dep = dependent_name;
		cls.pre = prerequisite_name;
		if (mode) begin
			cls.op = OP_RUN;
		end else if (dependent_name == prerequisite_name) begin
			cls.op = OP_SELF;
		end else begin
			cls.op = OP_ADD;
		end
	end

	assign item_stall = (fill_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (fill_q != 2'd0);
	assign cmd        = queue_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ----- rtl/core/dws_engine.sv -----
// back end: task table, dependency search, issue walk and readiness pass
module dws_engine #(
	parameter int MAX_TASKS = dws_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  dws_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	input  logic [dws_pkg::LIMIT_W-1:0]   issue_limit,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [dws_pkg::KIND_W-1:0]    result_kind,
	output logic [dws_pkg::NAME_W-1:0]    task_name,
	output logic                          last
);
	import dws_pkg::*;

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRCH_RD, ST_SRCH_CK, ST_DECIDE, ST_NEW_DEP, ST_NEW_PRE,
		ST_ROW_RD, ST_ROW_WR, ST_RUN_SCAN, ST_RUN_EMIT, ST_PASS_RD,
		ST_PASS_CK, ST_REPORT
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          count_q;
	logic                   fa_q, fb_q;
	logic [SW-1:0]          ia_q, ib_q, s_q;
	logic [LIMIT_W-1:0]     cnt_q, limit_q;
	kind_t                  rep_kind_q;
	logic [MAX_TASKS-1:0]   ready_q, exec_q;

	logic                   res_valid_q, res_last_q;
	kind_t                  res_kind_q;
	logic [NAME_W-1:0]      res_name_q;

	logic [NAME_W-1:0]      name_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0]   row_mem [MAX_TASKS];
	logic [NAME_W-1:0]      name_rd_q;
	logic [MAX_TASKS-1:0]   row_rd_q;

	logic                   name_we, row_we;
	logic [SW-1:0]          name_wa, name_ra, row_wa, row_ra;
	logic [NAME_W-1:0]      name_wd;
	logic [MAX_TASKS-1:0]   row_wd;

	logic                   out_free;
	logic [LIMIT_W-1:0]     lim_calc;
	logic [MAX_TASKS-1:0]   below_mask;
	logic                   fin;
	logic [CW:0]            need_total;
	logic [SW-1:0]          cur_slot;
	logic [SW-1:0]          dep_slot;

	assign out_free   = !res_valid_q || !result_stall;
	assign cur_slot   = count_q[SW-1:0];
	assign dep_slot   = fa_q ? ia_q : cur_slot;
	assign below_mask = (MAX_TASKS'(1) << s_q) - MAX_TASKS'(1);
	assign fin        = ((cnt_q + LIMIT_W'(1)) == limit_q) || ((ready_q & below_mask) == '0);
	assign need_total = (CW+1)'(count_q) + (CW+1)'(!fa_q) + (CW+1)'(!fb_q);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;

	// clamp the issue limit to one..MAX_RESULTS
	always_comb begin
		if (issue_limit == '0) begin
			lim_calc = LIMIT_W'(1);
		end else if (issue_limit > LIMIT_W'(MAX_RESULTS)) begin
			lim_calc = LIMIT_W'(MAX_RESULTS);
		end else begin
			lim_calc = issue_limit;
		end
	end

	// memory port control
	always_comb begin
		name_we = 1'b0;
		name_wa = cur_slot;
		name_wd = cmd_q.dep;
		name_ra = s_q;
		row_we  = 1'b0;
		row_wa  = ia_q;
		row_wd  = '0;
		row_ra  = s_q;
		case (state_q)
			ST_SRCH_RD: begin
				name_ra = idx_q[SW-1:0];
			end
			ST_NEW_DEP: begin
				name_we = !fa_q;
			end
			ST_NEW_PRE: begin
				name_we = !fb_q;
				name_wd = cmd_q.pre;
				row_we  = !fb_q;
				row_wa  = cur_slot;
			end
			ST_ROW_RD: begin
				row_ra = ia_q;
			end
			ST_ROW_WR: begin
				row_we = 1'b1;
				row_wd = (fa_q ? row_rd_q : '0) | (MAX_TASKS'(1) << ib_q);
			end
			default: begin
			end
		endcase
	end

	// name and prerequisite tables
	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[name_wa] <= name_wd;
		end
		name_rd_q <= name_mem[name_ra];
		if (row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		row_rd_q <= row_mem[row_ra];
	end

	// sequencer, task stages and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ready_q     <= '0;
			exec_q      <= '0;
			res_valid_q <= 1'b0;
			cmd_q       <= '0;
			idx_q       <= '0;
			fa_q        <= 1'b0;
			fb_q        <= 1'b0;
			ia_q        <= '0;
			ib_q        <= '0;
			s_q         <= '0;
			cnt_q       <= '0;
			limit_q     <= '0;
			rep_kind_q  <= KIND_NONE;
			res_kind_q  <= KIND_NONE;
			res_name_q  <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (out_free) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.op)
							OP_ADD: begin
								idx_q   <= '0;
								fa_q    <= 1'b0;
								fb_q    <= 1'b0;
								state_q <= ST_SRCH_RD;
							end
							OP_RUN: begin
								cnt_q   <= '0;
								limit_q <= lim_calc;
								if (count_q == '0) begin
									rep_kind_q <= KIND_NONE;
									state_q    <= ST_REPORT;
								end else begin
									s_q     <= SW'(count_q - CW'(1));
									state_q <= ST_RUN_SCAN;
								end
							end
							default: begin
								rep_kind_q <= KIND_REJECT;
								state_q    <= ST_REPORT;
							end
						endcase
					end
				end
				ST_SRCH_RD: begin
					state_q <= (idx_q == count_q) ? ST_DECIDE : ST_SRCH_CK;
				end
				ST_SRCH_CK: begin
					if (!fa_q && name_rd_q == cmd_q.dep) begin
						fa_q <= 1'b1;
						ia_q <= idx_q[SW-1:0];
					end
					if (!fb_q && name_rd_q == cmd_q.pre) begin
						fb_q <= 1'b1;
						ib_q <= idx_q[SW-1:0];
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_SRCH_RD;
				end
				ST_DECIDE: begin
					if (need_total > (CW+1)'(MAX_TASKS)) begin
						rep_kind_q <= KIND_REJECT;
						state_q    <= ST_REPORT;
					end else begin
						state_q <= ST_NEW_DEP;
					end
				end
				ST_NEW_DEP: begin
					ready_q[dep_slot] <= 1'b0;
					exec_q[dep_slot]  <= 1'b0;
					if (!fa_q) begin
						ia_q    <= cur_slot;
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_NEW_PRE;
				end
				ST_NEW_PRE: begin
					if (!fb_q) begin
						ib_q              <= cur_slot;
						ready_q[cur_slot] <= 1'b1;
						exec_q[cur_slot]  <= 1'b0;
						count_q           <= count_q + CW'(1);
					end
					state_q <= ST_ROW_RD;
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_WR;
				end
				ST_ROW_WR: begin
					rep_kind_q <= KIND_ACCEPT;
					state_q    <= ST_REPORT;
				end
				ST_RUN_SCAN: begin
					if (ready_q[s_q]) begin
						state_q <= ST_RUN_EMIT;
					end else if (s_q == '0) begin
						rep_kind_q <= KIND_NONE;
						state_q    <= ST_REPORT;
					end else begin
						s_q <= s_q - SW'(1);
					end
				end
				ST_RUN_EMIT: begin
					if (out_free) begin
						res_valid_q    <= 1'b1;
						res_kind_q     <= KIND_EXEC;
						res_name_q     <= name_rd_q;
						res_last_q     <= fin;
						exec_q[s_q]    <= 1'b1;
						ready_q[s_q]   <= 1'b0;
						cnt_q          <= cnt_q + LIMIT_W'(1);
						if (fin) begin
							s_q     <= '0;
							state_q <= ST_PASS_RD;
						end else begin
							s_q     <= s_q - SW'(1);
							state_q <= ST_RUN_SCAN;
						end
					end
				end
				ST_PASS_RD: begin
					state_q <= ST_PASS_CK;
				end
				ST_PASS_CK: begin
					if (!ready_q[s_q] && !exec_q[s_q] && (row_rd_q & ~exec_q) == '0) begin
						ready_q[s_q] <= 1'b1;
					end
					if (CW'(s_q) == count_q - CW'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= ST_PASS_RD;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= rep_kind_q;
						res_name_q  <= '0;
						res_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign task_name    = res_name_q;
	assign last         = res_last_q;

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("slot count above table size");

	// a task is never ready and executed at once
	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & exec_q) == '0)
		else $error("task both ready and executed");

	// single-word results always close their item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_kind_q != KIND_EXEC |-> res_last_q)
		else $error("single result without last");

	// a pass always follows a closing executed word
	a_pass_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN_EMIT && out_free && fin |=> state_q == ST_PASS_RD)
		else $error("readiness pass skipped");

endmodule

// ----- rtl/core/dependency_wave_scheduler.sv -----
// Dependency wave scheduler: a table of up to MAX_TASKS named tasks is kept as a name memory,
// a prerequisite-row memory and per-task ready/executed flags. An add word is taken from the
// queue, searches the names one slot at a time with a read and a check state per slot, then
// decides, writes any new dependent and prerequisite, updates the prerequisite row and reports.
// A run word scans the slots from newest to oldest and emits ready tasks up to the issue limit,
// then, after its last emitted task, sweeps every slot in a readiness pass (read, then check).
// Emitting and reporting wait while the result side stalls. Each table memory has a single
// read port. A two-word input queue lets the next word be taken while the engine works.
module dependency_wave_scheduler #(
	parameter int MAX_TASKS = dws_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dws_pkg::ADDR_W-1:0]    paddr,
	input  logic [dws_pkg::DATA_W-1:0]    pwdata,
	output logic [dws_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          mode,
	input  logic [dws_pkg::NAME_W-1:0]    dependent_name,
	input  logic [dws_pkg::NAME_W-1:0]    prerequisite_name,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [dws_pkg::KIND_W-1:0]    result_kind,
	output logic [dws_pkg::NAME_W-1:0]    task_name,
	output logic                          last
);
	import dws_pkg::*;

	logic [LIMIT_W-1:0] issue_limit_q;
	logic               cmd_valid;
	logic               cmd_pop;
	cmd_t               cmd;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_ISSUE_LIMIT);
	assign prdata  = reg_hit ? DATA_W'(issue_limit_q) : '0;

	// issue limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_limit_q <= ISSUE_LIMIT_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			issue_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	dws_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.mode              (mode),
		.dependent_name    (dependent_name),
		.prerequisite_name (prerequisite_name),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop)
	);

	dws_engine #(
		.MAX_TASKS (MAX_TASKS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.issue_limit  (issue_limit_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.task_name    (task_name),
		.last         (last)
	);

endmodule
